### rtl/tqbb_pkg.sv
// Shared types, widths, register indexes and fixed-point helpers for the
// transformed-quad bounding box pipeline. No dependencies.
`default_nettype none
package tqbb_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int COORD_BITS = 32;
   // Local corners carry one extra fraction bit: 2*pos +- size.
   localparam int LOC_W      = COORD_BITS + 2;
   // Exact product of a coordinate and a local corner value.
   localparam int PROD_W     = COORD_BITS + LOC_W;
   // Integer edges and their differences.
   localparam int INT_W      = LOC_W - FRAC_BITS + 2;
   localparam int DIFF_W     = INT_W + 1;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_VIEWPORT_MODE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VIEWPORT_WIDTH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VIEWPORT_HEIGHT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_X         = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_Y         = 3'd4;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [LOC_W-1:0]      local_type;
   typedef logic signed [PROD_W-1:0]     prod_type;
   typedef logic signed [INT_W-1:0]      int_type;
   typedef logic signed [DIFF_W-1:0]     diff_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } corner_type;

   // Configuration seen by the pipeline stages.
   typedef struct packed {
      logic        viewport_mode;
      logic [15:0] viewport_width;
      logic [15:0] viewport_height;
      coord_type   scale_x;
      coord_type   scale_y;
   } cfg_type;

   // Saturate a wide signed value to the coordinate range.
   function automatic coord_type sat_coord(input prod_type v);
      coord_type r;
      if (v[PROD_W-1:COORD_BITS-1] == '0 || v[PROD_W-1:COORD_BITS-1] == '1) begin
         r = v[COORD_BITS-1:0];
      end else if (v[PROD_W-1]) begin
         r = {1'b1, {(COORD_BITS-1){1'b0}}};
      end else begin
         r = {1'b0, {(COORD_BITS-1){1'b1}}};
      end
      return r;
   endfunction

   // Floor of a fixed-point value to a whole number.
   function automatic int_type fx_floor(input local_type v);
      local_type q;
      q = v >>> FRAC_BITS;
      return INT_W'(q);
   endfunction

   // Ceiling of a fixed-point value to a whole number.
   function automatic int_type fx_ceil(input local_type v);
      logic signed [LOC_W:0] t;
      t = (LOC_W+1)'(v) + (LOC_W+1)'((1 << FRAC_BITS) - 1);
      t = t >>> FRAC_BITS;
      return INT_W'(t);
   endfunction

   // Round half away from zero.
   function automatic int_type fx_round(input local_type v);
      logic signed [LOC_W:0] t;
      logic signed [LOC_W:0] half;
      half = (LOC_W+1)'(1 << (FRAC_BITS - 1));
      if (!v[LOC_W-1]) begin
         t = ((LOC_W+1)'(v) + half) >>> FRAC_BITS;
      end else begin
         t = -(((-(LOC_W+1)'(v)) + half) >>> FRAC_BITS);
      end
      return INT_W'(t);
   endfunction

   function automatic logic signed [15:0] clamp_edge(input int_type v);
      logic signed [15:0] r;
      if (v > INT_W'(32767)) begin
         r = 16'sh7fff;
      end else if (v < -INT_W'(32768)) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   function automatic logic signed [16:0] clamp_span(input diff_type v);
      logic signed [16:0] r;
      if (v > DIFF_W'(65535)) begin
         r = 17'sh0ffff;
      end else if (v < -DIFF_W'(65536)) begin
         r = 17'sh10000;
      end else begin
         r = v[16:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

### rtl/tqbb_if.sv
// Channel interfaces for request words (transform and rectangle) and
// response words (bounding box). No dependencies.
`default_nettype none
interface tqbb_req_if;
   logic                valid;
   logic                ready;
   logic signed [31:0]  mat_xx;
   logic signed [31:0]  mat_xy;
   logic signed [31:0]  mat_yx;
   logic signed [31:0]  mat_yy;
   logic signed [31:0]  shift_x;
   logic signed [31:0]  shift_y;
   logic signed [31:0]  pos_x;
   logic signed [31:0]  pos_y;
   logic        [30:0]  size_x;
   logic        [30:0]  size_y;

   modport source (output valid, mat_xx, mat_xy, mat_yx, mat_yy, shift_x, shift_y,
                   pos_x, pos_y, size_x, size_y, input ready);
   modport sink   (input valid, mat_xx, mat_xy, mat_yx, mat_yy, shift_x, shift_y,
                   pos_x, pos_y, size_x, size_y, output ready);
endinterface

interface tqbb_rsp_if;
   logic                valid;
   logic                ready;
   logic signed [15:0]  box_x;
   logic signed [15:0]  box_y;
   logic signed [16:0]  box_width;
   logic signed [16:0]  box_height;

   modport source (output valid, box_x, box_y, box_width, box_height, input ready);
   modport sink   (input valid, box_x, box_y, box_width, box_height, output ready);
endinterface
`default_nettype wire

### rtl/transformed_quad_bounding_box.sv
// Axis-aligned bounding box of an affine-transformed rectangle. The block is an
// eight-stage pipeline that takes one request word per cycle unless held; the
// whole pipeline moves together and holds while the response register is full
// and not taken, so throughput is one word per cycle when not held. Configuration
// must be written through the csr_ port only while no word is in flight; the
// block does not enforce this. Depends on tqbb_pkg, tqbb_if, tqbb_corner,
// tqbb_scale and tqbb_extent.
`default_nettype none
module transformed_quad_bounding_box (
   input  wire logic                          clock,
   input  wire logic                          reset,
   tqbb_req_if.sink                           req_chan,
   tqbb_rsp_if.source                         rsp_chan,
   input  wire logic                          csr_we,
   input  wire logic [tqbb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [tqbb_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tqbb_pkg::*;

   // Configuration registers.
   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.viewport_mode   <= 1'b0;
         cfg_ff.viewport_width  <= '0;
         cfg_ff.viewport_height <= '0;
         cfg_ff.scale_x         <= COORD_BITS'(1 << FRAC_BITS);
         cfg_ff.scale_y         <= COORD_BITS'(1 << FRAC_BITS);
      end else if (csr_we) begin
         case (csr_index)
            CSR_VIEWPORT_MODE:   cfg_ff.viewport_mode   <= csr_wdata[0];
            CSR_VIEWPORT_WIDTH:  cfg_ff.viewport_width  <= csr_wdata[15:0];
            CSR_VIEWPORT_HEIGHT: cfg_ff.viewport_height <= csr_wdata[15:0];
            CSR_SCALE_X:         cfg_ff.scale_x         <= csr_wdata[31:0];
            CSR_SCALE_Y:         cfg_ff.scale_y         <= csr_wdata[31:0];
            default: begin
            end
         endcase
      end
   end

   // The pipeline advances whenever the response register is free or taken.
   logic       adv;
   logic       out_vld;
   logic       corner_vld, scale_vld;
   corner_type corner3 [3];
   corner_type corner4 [4];

   assign adv            = !out_vld || rsp_chan.ready;
   assign req_chan.ready = adv;
   assign rsp_chan.valid = out_vld;

   tqbb_corner u_corner (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .vld_in  (req_chan.valid),
      .mat_xx  (req_chan.mat_xx),
      .mat_xy  (req_chan.mat_xy),
      .mat_yx  (req_chan.mat_yx),
      .mat_yy  (req_chan.mat_yy),
      .shift_x (req_chan.shift_x),
      .shift_y (req_chan.shift_y),
      .pos_x   (req_chan.pos_x),
      .pos_y   (req_chan.pos_y),
      .size_x  (req_chan.size_x),
      .size_y  (req_chan.size_y),
      .vld_out (corner_vld),
      .corner  (corner3)
   );

   tqbb_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .cfg        (cfg_ff),
      .vld_in     (corner_vld),
      .corner_in  (corner3),
      .vld_out    (scale_vld),
      .corner_out (corner4)
   );

   tqbb_extent u_extent (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .cfg        (cfg_ff),
      .vld_in     (scale_vld),
      .corner     (corner4),
      .vld_out    (out_vld),
      .box_x      (rsp_chan.box_x),
      .box_y      (rsp_chan.box_y),
      .box_width  (rsp_chan.box_width),
      .box_height (rsp_chan.box_height)
   );

endmodule
`default_nettype wire

### rtl/tqbb_corner.sv
// Corner transform: local corners, matrix products and translated sums over
// three register stages. Depends on tqbb_pkg.
`default_nettype none
module tqbb_corner (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 adv,
   input  wire logic                 vld_in,
   input  wire logic signed [31:0]   mat_xx,
   input  wire logic signed [31:0]   mat_xy,
   input  wire logic signed [31:0]   mat_yx,
   input  wire logic signed [31:0]   mat_yy,
   input  wire logic signed [31:0]   shift_x,
   input  wire logic signed [31:0]   shift_y,
   input  wire logic signed [31:0]   pos_x,
   input  wire logic signed [31:0]   pos_y,
   input  wire logic        [30:0]   size_x,
   input  wire logic        [30:0]   size_y,
   output logic                      vld_out,
   output tqbb_pkg::corner_type      corner [3]
);
   import tqbb_pkg::*;

   // Stage one: local corner coordinates with one extra fraction bit.
   logic      s1_vld_ff;
   local_type xa_ff, xb_ff, ya_ff, yb_ff;
   coord_type mxx_ff, mxy_ff, myx_ff, myy_ff, tx1_ff, ty1_ff;
   local_type p2x, p2y, szx, szy;

   always_comb begin
      p2x = {pos_x[31], pos_x, 1'b0};
      p2y = {pos_y[31], pos_y, 1'b0};
      szx = {3'b000, size_x};
      szy = {3'b000, size_y};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         xa_ff  <= p2x - szx;
         xb_ff  <= p2x + szx;
         ya_ff  <= p2y - szy;
         yb_ff  <= p2y + szy;
         mxx_ff <= mat_xx;
         mxy_ff <= mat_xy;
         myx_ff <= mat_yx;
         myy_ff <= mat_yy;
         tx1_ff <= shift_x;
         ty1_ff <= shift_y;
      end
   end

   // Stage two: the eight exact products.
   logic      s2_vld_ff;
   prod_type  pxxa_ff, pxxb_ff, pyxa_ff, pyxb_ff;
   prod_type  pxya_ff, pxyb_ff, pyya_ff, pyyb_ff;
   coord_type tx2_ff, ty2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (adv) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pxxa_ff <= mxx_ff * xa_ff;
         pxxb_ff <= mxx_ff * xb_ff;
         pyxa_ff <= myx_ff * ya_ff;
         pyxb_ff <= myx_ff * yb_ff;
         pxya_ff <= mxy_ff * xa_ff;
         pxyb_ff <= mxy_ff * xb_ff;
         pyya_ff <= myy_ff * ya_ff;
         pyyb_ff <= myy_ff * yb_ff;
         tx2_ff  <= tx1_ff;
         ty2_ff  <= ty1_ff;
      end
   end

   // Stage three: floor and saturate each product, then add the translation.
   logic       s3_vld_ff;
   corner_type c_ff [3];
   coord_type  fxxa, fxxb, fyxa, fyxb, fxya, fxyb, fyya, fyyb;
   corner_type c_in [3];

   always_comb begin
      fxxa = sat_coord(pxxa_ff >>> (FRAC_BITS + 1));
      fxxb = sat_coord(pxxb_ff >>> (FRAC_BITS + 1));
      fyxa = sat_coord(pyxa_ff >>> (FRAC_BITS + 1));
      fyxb = sat_coord(pyxb_ff >>> (FRAC_BITS + 1));
      fxya = sat_coord(pxya_ff >>> (FRAC_BITS + 1));
      fxyb = sat_coord(pxyb_ff >>> (FRAC_BITS + 1));
      fyya = sat_coord(pyya_ff >>> (FRAC_BITS + 1));
      fyyb = sat_coord(pyyb_ff >>> (FRAC_BITS + 1));
      c_in[0].x = sat_coord(PROD_W'(fxxa) + PROD_W'(fyxa) + PROD_W'(tx2_ff));
      c_in[0].y = sat_coord(PROD_W'(fxya) + PROD_W'(fyya) + PROD_W'(ty2_ff));
      c_in[1].x = sat_coord(PROD_W'(fxxb) + PROD_W'(fyxa) + PROD_W'(tx2_ff));
      c_in[1].y = sat_coord(PROD_W'(fxyb) + PROD_W'(fyya) + PROD_W'(ty2_ff));
      c_in[2].x = sat_coord(PROD_W'(fxxb) + PROD_W'(fyxb) + PROD_W'(tx2_ff));
      c_in[2].y = sat_coord(PROD_W'(fxyb) + PROD_W'(fyyb) + PROD_W'(ty2_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (adv) begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_ff <= c_in;
      end
   end

   assign vld_out = s3_vld_ff;
   assign corner  = c_ff;

endmodule
`default_nettype wire

### rtl/tqbb_scale.sv
// Viewport scaling of three corners and derivation of the fourth corner,
// over two register stages. Depends on tqbb_pkg.
`default_nettype none
module tqbb_scale (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 adv,
   input  wire tqbb_pkg::cfg_type    cfg,
   input  wire logic                 vld_in,
   input  wire tqbb_pkg::corner_type corner_in [3],
   output logic                      vld_out,
   output tqbb_pkg::corner_type      corner_out [4]
);
   import tqbb_pkg::*;

   // Stage four: scale products; in transform mode the corner is lined up
   // so that the common shift below returns it unchanged.
   logic     s4_vld_ff;
   prod_type px_ff [3];
   prod_type py_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (adv) begin
         s4_vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            if (cfg.viewport_mode) begin
               px_ff[i] <= PROD_W'(corner_in[i].x) * PROD_W'(cfg.scale_x);
               py_ff[i] <= PROD_W'(corner_in[i].y) * PROD_W'(cfg.scale_y);
            end else begin
               px_ff[i] <= PROD_W'(corner_in[i].x) <<< FRAC_BITS;
               py_ff[i] <= PROD_W'(corner_in[i].y) <<< FRAC_BITS;
            end
         end
      end
   end

   // Stage five: floor and saturate, then the fourth corner c0 + c2 - c1.
   logic       s5_vld_ff;
   corner_type c_ff [4];
   corner_type c_in [4];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         c_in[i].x = sat_coord(px_ff[i] >>> FRAC_BITS);
         c_in[i].y = sat_coord(py_ff[i] >>> FRAC_BITS);
      end
      c_in[3].x = sat_coord(PROD_W'(c_in[0].x) + PROD_W'(c_in[2].x) - PROD_W'(c_in[1].x));
      c_in[3].y = sat_coord(PROD_W'(c_in[0].y) + PROD_W'(c_in[2].y) - PROD_W'(c_in[1].y));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else if (adv) begin
         s5_vld_ff <= s4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_ff <= c_in;
      end
   end

   assign vld_out    = s5_vld_ff;
   assign corner_out = c_ff;

endmodule
`default_nettype wire

### rtl/tqbb_extent.sv
// Corner selection, conversion to whole units and box formation over three
// register stages; the last stage is the response register. Depends on tqbb_pkg.
`default_nettype none
module tqbb_extent (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 adv,
   input  wire tqbb_pkg::cfg_type    cfg,
   input  wire logic                 vld_in,
   input  wire tqbb_pkg::corner_type corner [4],
   output logic                      vld_out,
   output logic signed [15:0]        box_x,
   output logic signed [15:0]        box_y,
   output logic signed [16:0]        box_width,
   output logic signed [16:0]        box_height
);
   import tqbb_pkg::*;

   // Stage six: leftmost corner (first on ties) and the opposite edges.
   logic       s6_vld_ff, s6_mode_ff;
   local_type  lo_x_ff, lo_y_ff, hi_x_ff, hi_y_ff;
   logic [1:0] sel;
   local_type  ax, ay, bx, by, hw, hh;

   always_comb begin
      sel = 2'd0;
      for (int i = 1; i < 4; i++) begin
         if (corner[i].x < corner[sel].x) begin
            sel = 2'(i);
         end
      end
      ax = LOC_W'(corner[sel].x);
      ay = LOC_W'(corner[sel + 2'd3].y);
      bx = LOC_W'(corner[sel + 2'd2].x);
      by = LOC_W'(corner[sel + 2'd1].y);
      hw = LOC_W'(cfg.viewport_width)  <<< (FRAC_BITS - 1);
      hh = LOC_W'(cfg.viewport_height) <<< (FRAC_BITS - 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_vld_ff <= 1'b0;
      end else if (adv) begin
         s6_vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s6_mode_ff <= cfg.viewport_mode;
         if (cfg.viewport_mode) begin
            lo_x_ff <= hw - bx;
            lo_y_ff <= hh - by;
            hi_x_ff <= hw - ax;
            hi_y_ff <= hh - ay;
         end else begin
            lo_x_ff <= ax;
            lo_y_ff <= ay;
            hi_x_ff <= bx;
            hi_y_ff <= by;
         end
      end
   end

   // Stage seven: whole-unit edges.
   logic    s7_vld_ff, s7_mode_ff;
   int_type x_ff, y_ff, z_ff, w_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_vld_ff <= 1'b0;
      end else if (adv) begin
         s7_vld_ff <= s6_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s7_mode_ff <= s6_mode_ff;
         x_ff       <= fx_floor(lo_x_ff);
         y_ff       <= fx_floor(lo_y_ff);
         z_ff       <= s6_mode_ff ? fx_round(hi_x_ff) : fx_ceil(hi_x_ff);
         w_ff       <= s6_mode_ff ? fx_round(hi_y_ff) : fx_ceil(hi_y_ff);
      end
   end

   // Stage eight: spans, absolute height in transform mode, clamping.
   logic               s8_vld_ff;
   logic signed [15:0] bx_ff, by_ff;
   logic signed [16:0] bw_ff, bh_ff;
   diff_type           wd, ht;

   always_comb begin
      wd = DIFF_W'(z_ff) - DIFF_W'(x_ff);
      ht = DIFF_W'(w_ff) - DIFF_W'(y_ff);
      if (!s7_mode_ff && ht[DIFF_W-1]) begin
         ht = -ht;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_vld_ff <= 1'b0;
      end else if (adv) begin
         s8_vld_ff <= s7_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         bx_ff <= clamp_edge(x_ff);
         by_ff <= clamp_edge(y_ff);
         bw_ff <= clamp_span(wd);
         bh_ff <= clamp_span(ht);
      end
   end

   assign vld_out    = s8_vld_ff;
   assign box_x      = bx_ff;
   assign box_y      = by_ff;
   assign box_width  = bw_ff;
   assign box_height = bh_ff;

endmodule
`default_nettype wire

### rtl/tqbb_checker.sv
// Port-level checks on the bounding box block and the bind that attaches
// them to it. Depends on transformed_quad_bounding_box.
`default_nettype none
module tqbb_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [65:0] rsp_word
);
   // A held response word keeps its valid.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response valid dropped while stalled");

   // A held response word keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_word))
      else $error("response word changed while stalled");

   // Requests are refused only when the response register is full and held.
   assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("request ready does not follow the output stage");

   // Reset empties the pipeline.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");
endmodule

bind transformed_quad_bounding_box tqbb_checker u_tqbb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_word  ({rsp_chan.box_x, rsp_chan.box_y, rsp_chan.box_width, rsp_chan.box_height})
);
`default_nettype wire
